// File: design/tilt_compensated_heading_unit_macros.svh
// Assertion macros shared by the heading unit checkers.
`ifndef TILT_COMPENSATED_HEADING_UNIT_MACROS_SVH
`define TILT_COMPENSATED_HEADING_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCH_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heading unit same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heading unit next-cycle check failed");

`endif

// File: design/tch_pkg.sv
// Shared types, constants and constant functions for the heading unit.
package tch_pkg;

    localparam int DW         = 36;
    localparam int QDEPTH     = 4;
    localparam int MAX_STAGES = 24;

    // round(atan(2^-i) * 2^30)
    localparam longint ATAN_Q30 [MAX_STAGES] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
        64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
        64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128
    };

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = PI_Q30 >>> 1;
    localparam longint TWO_PI_Q30  = 2 * PI_Q30;

    // centidegree conversion: q ~= |a| * CDEG_RECIP >> CDEG_SHIFT, then one correction
    localparam int     CDEG_SHIFT  = 47;
    localparam longint CDEG_RECIP  = (64'sd36000 <<< CDEG_SHIFT) / TWO_PI_Q30;
    localparam int     CDEG_RW     = 30;
    localparam int     CDEG_MAG_W  = 33;
    localparam int     CDEG_N_W    = 50;
    localparam int     CDEG_Q_W    = 17;

    typedef logic signed [DW-1:0] q30_t;

    typedef enum logic {
        CM_VECTOR,
        CM_ROTATE
    } cordic_mode_t;

    typedef struct packed {
        q30_t ax;
        q30_t ay;
        q30_t az;
        q30_t mx;
        q30_t my;
        q30_t mz;
    } sample_vec_t;

    // CORDIC gain correction in Q30 for a given stage count
    function automatic longint k_q30(input int stages);
        longint unsigned k2;
        longint unsigned d;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        k2 = 64'd1 << 60;
        for (int i = 0; i < stages; i++)
        begin
            // k2 - floor(k2 / (4^i + 1)), quotient by shift and subtract
            d   = (64'd1 << (2 * i)) + 64'd1;
            q   = 0;
            rem = 0;
            for (int bi = 60; bi >= 0; bi--)
            begin
                rem = (rem << 1) | ((k2 >> bi) & 64'd1);
                if (rem >= d)
                begin
                    rem = rem - d;
                    q   = q | (64'd1 << bi);
                end
            end
            k2 = k2 - q;
        end
        v = k2;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

endpackage

// File: design/tch_front.sv
// Input side: accepts requests, scales samples to Q30 and queues them.
module tch_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TDATA_W      = 96
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,
    output logic                q_valid,
    input  logic                q_pop,
    output tch_pkg::sample_vec_t q_item
);
    import tch_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);
    localparam int SH = 30 - SAMPLE_WIDTH;

    sample_vec_t    mem [QDEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  count_reg, count_next;
    sample_vec_t    scaled;
    logic           push;

    function automatic q30_t scale(input logic [SAMPLE_WIDTH-1:0] raw);
        q30_t v;
        v = q30_t'($signed(raw));
        return v <<< SH;
    endfunction

    always_comb
    begin
        scaled.ax = scale(s_tdata[0*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
        scaled.ay = scale(s_tdata[1*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
        scaled.az = scale(s_tdata[2*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
        scaled.mx = scale(s_tdata[3*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
        scaled.my = scale(s_tdata[4*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
        scaled.mz = scale(s_tdata[5*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
    end

    assign s_tready = (count_reg != CW'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = push  ? wptr_reg + PW'(1) : wptr_reg;
        rptr_next  = q_pop ? rptr_reg + PW'(1) : rptr_reg;
        count_next = count_reg + CW'(push) - CW'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= scaled;
        end
    end

endmodule

// File: design/tch_cordic.sv
// Pipelined CORDIC, vectoring or rotation, with gain correction at the end.
module tch_cordic #(
    parameter int                   STAGES = 16,
    parameter tch_pkg::cordic_mode_t MODE  = tch_pkg::CM_VECTOR,
    parameter int                   SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  tch_pkg::q30_t        in_x,
    input  tch_pkg::q30_t        in_y,
    input  tch_pkg::q30_t        in_z,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output tch_pkg::q30_t        out_x,
    output tch_pkg::q30_t        out_y,
    output tch_pkg::q30_t        out_z,
    output logic [SIDE_W-1:0]    out_side
);
    import tch_pkg::*;

    localparam int            KW    = 30;
    localparam int            LO_W  = 18;
    localparam int            HI_W  = DW - 1 - LO_W;
    localparam int            SUM_W = DW + KW;
    localparam logic [KW-1:0] K_C   = KW'(k_q30(STAGES));
    localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (KW - 1);

    q30_t              x_reg    [STAGES+1];
    q30_t              y_reg    [STAGES+1];
    q30_t              z_reg    [STAGES+1];
    logic              zero_reg [STAGES+1];
    logic              valid_reg[STAGES+1];
    logic [SIDE_W-1:0] side_reg [STAGES+1];

    q30_t x0, y0, z0;
    logic zf0;

    // quadrant pre-step
    always_comb
    begin
        x0  = in_x;
        y0  = in_y;
        z0  = in_z;
        zf0 = 1'b0;
        if (MODE == CM_VECTOR)
        begin
            z0  = '0;
            zf0 = (in_x == '0) && (in_y == '0);
            if (in_x < 0)
            begin
                z0 = (in_y >= 0) ? q30_t'(PI_Q30) : q30_t'(-PI_Q30);
                x0 = -in_x;
                y0 = -in_y;
            end
        end
        else
        begin
            if (in_z > q30_t'(HALF_PI_Q30))
            begin
                z0 = in_z - q30_t'(PI_Q30);
                x0 = -in_x;
                y0 = -in_y;
            end
            else if (in_z < q30_t'(-HALF_PI_Q30))
            begin
                z0 = in_z + q30_t'(PI_Q30);
                x0 = -in_x;
                y0 = -in_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0;
            y_reg[0]    <= y0;
            z_reg[0]    <= z0;
            zero_reg[0] <= zf0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam q30_t AT = q30_t'(ATAN_Q30[i]);
        q30_t dx, dy, xn, yn, zn;
        logic up;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign up = (MODE == CM_VECTOR) ? !y_reg[i][DW-1] : z_reg[i][DW-1];

        // up: drive y toward zero from above (vectoring) or z toward zero from below (rotation)
        always_comb
        begin
            if (up)
            begin
                xn = x_reg[i] + dx;
                yn = y_reg[i] - dy;
                zn = (MODE == CM_VECTOR) ? z_reg[i] + AT : z_reg[i] + AT;
            end
            else
            begin
                xn = x_reg[i] - dx;
                yn = y_reg[i] + dy;
                zn = z_reg[i] - AT;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= xn;
                y_reg[i+1]    <= yn;
                z_reg[i+1]    <= zn;
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // gain correction: split product, then round half away from zero
    logic              a_valid_reg;
    q30_t              a_z_reg;
    logic [SIDE_W-1:0] a_side_reg;
    logic              a_neg_reg [2];
    logic [LO_W+KW-1:0] a_lo_reg [2];
    logic [HI_W+KW-1:0] a_hi_reg [2];

    logic              b_valid_reg;
    q30_t              b_z_reg;
    logic [SIDE_W-1:0] b_side_reg;
    q30_t              b_v_reg [2];

    q30_t mk_src [2];
    assign mk_src[0] = x_reg[STAGES];
    assign mk_src[1] = y_reg[STAGES];

    for (genvar j = 0; j < 2; j++)
    begin : g_mulk
        logic [DW-2:0]      mag;
        logic [SUM_W-1:0]   sum;
        q30_t               res;

        assign mag = mk_src[j][DW-1] ? (DW-1)'(-mk_src[j]) : (DW-1)'(mk_src[j]);
        assign sum = (SUM_W'(a_hi_reg[j]) << LO_W) + SUM_W'(a_lo_reg[j]) + RND;
        assign res = sum[SUM_W-1:KW];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_neg_reg[j] <= mk_src[j][DW-1];
                a_lo_reg[j]  <= (LO_W+KW)'(mag[LO_W-1:0]) * (LO_W+KW)'(K_C);
                a_hi_reg[j]  <= (HI_W+KW)'(mag[DW-2:LO_W]) * (HI_W+KW)'(K_C);
                b_v_reg[j]   <= a_neg_reg[j] ? -res : res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= valid_reg[STAGES];
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_z_reg    <= zero_reg[STAGES] ? '0 : z_reg[STAGES];
            a_side_reg <= side_reg[STAGES];
            b_z_reg    <= a_z_reg;
            b_side_reg <= a_side_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_x     = b_v_reg[0];
    assign out_y     = b_v_reg[1];
    assign out_z     = b_z_reg;
    assign out_side  = b_side_reg;

endmodule

// File: design/tch_cdeg.sv
// Q30 radians to rounded, clamped centidegrees, four pipeline stages.
module tch_cdeg #(
    parameter int LIM = 18000
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  tch_pkg::q30_t                         angle,
    output logic                                  out_valid,
    output logic signed [tch_pkg::CDEG_Q_W-1:0]   centideg
);
    import tch_pkg::*;

    localparam int PW = CDEG_MAG_W + CDEG_RW;
    localparam int QW = CDEG_Q_W;
    localparam logic [CDEG_RW-1:0] RECIP_C = CDEG_RW'(CDEG_RECIP);

    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic                   n1_reg, n2_reg, n3_reg;
    logic [PW-1:0]          pc1_reg;
    logic [CDEG_N_W-1:0]    pn1_reg, n2v_reg, n3v_reg, t3_reg;
    logic [QW-2:0]          q2_reg;
    logic [QW-1:0]          qi3_reg, q3_reg;
    logic signed [QW-1:0]   out_reg;

    logic [DW-1:0]          absv;
    logic [CDEG_MAG_W-1:0]  m;
    logic [QW-1:0]          qsel, qclp;

    assign absv = angle[DW-1] ? DW'(-angle) : DW'(angle);
    assign m    = absv[CDEG_MAG_W-1:0];

    always_comb
    begin
        qsel = (n3v_reg >= t3_reg) ? qi3_reg : q3_reg;
        qclp = (qsel > QW'(LIM)) ? QW'(LIM) : qsel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg  <= angle[DW-1];
            pc1_reg <= PW'(m) * PW'(RECIP_C);
            pn1_reg <= CDEG_N_W'(m) * CDEG_N_W'(36000);

            n2_reg  <= n1_reg;
            q2_reg  <= pc1_reg[CDEG_SHIFT+QW-2:CDEG_SHIFT];
            n2v_reg <= pn1_reg + CDEG_N_W'(PI_Q30);

            n3_reg  <= n2_reg;
            n3v_reg <= n2v_reg;
            q3_reg  <= QW'(q2_reg);
            qi3_reg <= QW'(q2_reg) + QW'(1);
            t3_reg  <= CDEG_N_W'(QW'(q2_reg) + QW'(1)) * CDEG_N_W'(TWO_PI_Q30);

            out_reg <= n3_reg ? -$signed(qclp) : $signed(qclp);
        end
    end

    assign out_valid = v4_reg;
    assign centideg  = out_reg;

endmodule

// File: design/tch_back.sv
// Execution side: roll, pitch, tilt compensation, heading and output register.
module tch_back #(
    parameter int STAGES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  tch_pkg::sample_vec_t q_item,
    output logic                 q_pop,
    input  logic signed [15:0]   decl,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata
);
    import tch_pkg::*;

    logic adv;
    logic out_valid_reg;
    logic [47:0] out_data_reg;

    // whole pipeline moves together; stalls only when the output register is held
    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv && q_valid;

    logic             v1_valid, v2_valid, r1_valid, r2_valid, v3_valid;
    q30_t             v1_x, v1_z, v2_z, r1_x, r1_y, r2_x, v3_z, v2_y, r1_z;
    logic [4*DW-1:0]  v1_side, v2_side;
    logic [3*DW-1:0]  r1_side, r2_side;
    logic [2*DW-1:0]  v3_side;

    tch_cordic #(.STAGES(STAGES), .MODE(CM_VECTOR), .SIDE_W(4*DW)) u_roll (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(q_valid),
        .in_x(q_item.az), .in_y(q_item.ay), .in_z('0),
        .in_side({q_item.ax, q_item.mx, q_item.my, q_item.mz}),
        .out_valid(v1_valid), .out_x(v1_x), .out_y(), .out_z(v1_z), .out_side(v1_side)
    );

    assign v2_y = -q30_t'(v1_side[4*DW-1 -: DW]);

    tch_cordic #(.STAGES(STAGES), .MODE(CM_VECTOR), .SIDE_W(4*DW)) u_pitch (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v1_valid),
        .in_x(v1_x), .in_y(v2_y), .in_z('0),
        .in_side({v1_z, v1_side[3*DW-1:0]}),
        .out_valid(v2_valid), .out_x(), .out_y(), .out_z(v2_z), .out_side(v2_side)
    );

    assign r1_z = -v2_z;

    // rotate mag by -pitch about y
    tch_cordic #(.STAGES(STAGES), .MODE(CM_ROTATE), .SIDE_W(3*DW)) u_rot_p (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v2_valid),
        .in_x(v2_side[3*DW-1 -: DW]), .in_y(v2_side[DW-1:0]), .in_z(r1_z),
        .in_side({v2_side[4*DW-1 -: DW], v2_z, v2_side[2*DW-1 -: DW]}),
        .out_valid(r1_valid), .out_x(r1_x), .out_y(r1_y), .out_z(), .out_side(r1_side)
    );

    // then by roll about x
    tch_cordic #(.STAGES(STAGES), .MODE(CM_ROTATE), .SIDE_W(3*DW)) u_rot_r (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(r1_valid),
        .in_x(r1_side[DW-1:0]), .in_y(r1_y), .in_z(r1_side[3*DW-1 -: DW]),
        .in_side({r1_side[3*DW-1:DW], r1_x}),
        .out_valid(r2_valid), .out_x(r2_x), .out_y(), .out_z(), .out_side(r2_side)
    );

    tch_cordic #(.STAGES(STAGES), .MODE(CM_VECTOR), .SIDE_W(2*DW)) u_head (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(r2_valid),
        .in_x(r2_side[DW-1:0]), .in_y(r2_x), .in_z('0),
        .in_side(r2_side[3*DW-1:DW]),
        .out_valid(v3_valid), .out_x(), .out_y(), .out_z(v3_z), .out_side(v3_side)
    );

    logic                       c_valid;
    logic signed [CDEG_Q_W-1:0] c_roll, c_pitch, c_head;
    logic signed [16:0]         head_sum;

    tch_cdeg #(.LIM(18000)) u_cdeg_roll (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v3_valid),
        .angle(v3_side[2*DW-1 -: DW]), .out_valid(c_valid), .centideg(c_roll)
    );

    tch_cdeg #(.LIM(9000)) u_cdeg_pitch (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v3_valid),
        .angle(v3_side[DW-1:0]), .out_valid(), .centideg(c_pitch)
    );

    tch_cdeg #(.LIM(18000)) u_cdeg_head (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v3_valid),
        .angle(v3_z), .out_valid(), .centideg(c_head)
    );

    assign head_sum = 17'(c_head) + {decl[15], decl};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {head_sum, c_pitch[14:0], c_roll[15:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: design/tilt_compensated_heading_unit.sv
// Tilt-compensated compass: roll, pitch and declination-corrected heading.
// Throughput: one request per cycle while the output is not held, no dependence between samples.
// Datapath from input accept to m_tvalid: five chained CORDIC pipelines,
//   then the four-stage degree converter and the output register.
// Reset: queue, pipeline valids and output clear; declination resets to zero.
module tilt_compensated_heading_unit #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z from bit 0 up, zero padded
    input  logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // roll_centideg[15:0], pitch_centideg[30:16], heading_centideg[47:31]
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import tch_pkg::*;

    localparam int TDATA_W = ((6*SAMPLE_WIDTH+7)/8)*8;

    logic signed [15:0] decl_reg;
    logic               q_valid, q_pop;
    sample_vec_t        q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= '0;
        end
        else if (cfg_we)
        begin
            decl_reg <= cfg_wdata;
        end
    end

    tch_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .TDATA_W(TDATA_W)) u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    tch_back #(.STAGES(CORDIC_STAGES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .decl(decl_reg),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule

// File: design/tch_checker.sv
// Port-level checks for the heading unit, bound to the top level.
`include "tilt_compensated_heading_unit_macros.svh"

module tch_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    `TCH_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `TCH_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    `TCH_ASSERT_SAME(a_roll_range, clk, rst_n, m_tvalid, ($signed(m_tdata[15:0]) <= 16'sd18000) && ($signed(m_tdata[15:0]) >= -16'sd18000))
    `TCH_ASSERT_SAME(a_pitch_range, clk, rst_n, m_tvalid, ($signed(m_tdata[30:16]) <= 15'sd9000) && ($signed(m_tdata[30:16]) >= -15'sd9000))

endmodule

bind tilt_compensated_heading_unit tch_checker u_tch_checker (
    .clk(clk),
    .rst_n(rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

// File: tb/sv/tilt_compensated_heading_unit_tb.sv
// Testbench for the tilt-compensated heading unit: random and directed samples, scored.
module tilt_compensated_heading_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW          = 16;
    localparam int STAGES      = 16;
    localparam int PIPE_LAT    = 5 * (STAGES + 3) + 5;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [16:0] heading;
        logic [14:0] pitch;
        logic [15:0] roll;
    } attitude_t;

    // Expected attitude store with its own fixed-point compass model.
    class attitude_board;
        attitude_t  expected_q[$];
        int         errors;
        longint     k_gain;
        logic [15:0] declination;

        function new();
            longint k2;
            longint unsigned v, r, b;
            errors      = 0;
            declination = '0;
            k2 = longint'(1) <<< 60;
            for (int i = 0; i < STAGES; i++)
                k2 = k2 - k2 / ((longint'(1) <<< (2 * i)) + 1);
            v = k2;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            k_gain = longint'(r);
        endfunction

        function longint gain_fix(longint v);
            if (v < 0)
                return -((-v * k_gain + (longint'(1) <<< 29)) >>> 30);
            return (v * k_gain + (longint'(1) <<< 29)) >>> 30;
        endfunction

        function longint arc_tan2(longint x, longint y, output longint mag);
            longint z, dx, dy;
            z = 0;
            if (x == 0 && y == 0)
            begin
                mag = 0;
                return 0;
            end
            if (x < 0)
            begin
                z = (y >= 0) ? tch_pkg::PI_Q30 : -tch_pkg::PI_Q30;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x += dx; y -= dy; z += tch_pkg::ATAN_Q30[i];
                end
                else
                begin
                    x -= dx; y += dy; z -= tch_pkg::ATAN_Q30[i];
                end
            end
            mag = gain_fix(x);
            return z;
        endfunction

        function void turn(longint x, longint y, longint z, output longint ox, output longint oy);
            longint half, dx, dy;
            half = tch_pkg::PI_Q30 >>> 1;
            if (z > half)
            begin
                z -= tch_pkg::PI_Q30; x = -x; y = -y;
            end
            else if (z < -half)
            begin
                z += tch_pkg::PI_Q30; x = -x; y = -y;
            end
            for (int i = 0; i < STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= tch_pkg::ATAN_Q30[i];
                end
                else
                begin
                    x += dx; y -= dy; z += tch_pkg::ATAN_Q30[i];
                end
            end
            ox = gain_fix(x);
            oy = gain_fix(y);
        endfunction

        function longint centideg(longint a, longint lim);
            longint m, q;
            m = (a < 0) ? -a : a;
            q = (m * 36000 + tch_pkg::PI_Q30) / (2 * tch_pkg::PI_Q30);
            if (q > lim)
                q = lim;
            return (a < 0) ? -q : q;
        endfunction

        function void note_sample(logic [95:0] data);
            longint ax, ay, az, mx, my, mz;
            longint roll, pitch, head, r, unused, mxc, t, myc, tmp, hc;
            attitude_t e;
            ax = longint'($signed(data[15:0]))  <<< (30 - SW);
            ay = longint'($signed(data[31:16])) <<< (30 - SW);
            az = longint'($signed(data[47:32])) <<< (30 - SW);
            mx = longint'($signed(data[63:48])) <<< (30 - SW);
            my = longint'($signed(data[79:64])) <<< (30 - SW);
            mz = longint'($signed(data[95:80])) <<< (30 - SW);
            roll  = arc_tan2(az, ay, r);
            pitch = arc_tan2(r, -ax, unused);
            turn(mx, mz, -pitch, mxc, t);
            turn(my, t, roll, myc, tmp);
            head = arc_tan2(mxc, myc, unused);
            hc = centideg(head, 18000) + longint'($signed(declination));
            e.roll    = 16'(centideg(roll, 18000));
            e.pitch   = 15'(centideg(pitch, 9000));
            e.heading = 17'(hc);
            expected_q.push_back(e);
        endfunction

        function void check_result(logic [47:0] data);
            attitude_t got, e;
            got = data;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, data);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.roll !== e.roll)
            begin
                $display("%0t: roll expected %0d got %0d", $time,
                         $signed(e.roll), $signed(got.roll));
                errors++;
            end
            if (got.pitch !== e.pitch)
            begin
                $display("%0t: pitch expected %0d got %0d", $time,
                         $signed(e.pitch), $signed(got.pitch));
                errors++;
            end
            if (got.heading !== e.heading)
            begin
                $display("%0t: heading expected %0d got %0d", $time,
                         $signed(e.heading), $signed(got.heading));
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    attitude_board board;
    int  cycles;
    bit  calm;          // no idling on either side
    bit  hold_request;  // receiver holds off for a long stretch
    int  hold_left;

    tilt_compensated_heading_unit #(
        .SAMPLE_WIDTH (SW),
        .CORDIC_STAGES(STAGES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: score accepted results, then choose next tready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 400;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= 22);
    end

    task automatic send_sample(input logic [95:0] data);
        while (!calm && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_sample(data);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_declination(input logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.declination = v;
    endtask

    function automatic logic [95:0] pack_axes(int ax, int ay, int az, int mx, int my, int mz);
        return {16'(mz), 16'(my), 16'(mx), 16'(az), 16'(ay), 16'(ax)};
    endfunction

    function automatic logic [95:0] random_sample();
        int kind;
        logic [95:0] d;
        kind = $urandom_range(99);
        if (kind < 55)
        begin
            // near-level device in a moderate field
            d = pack_axes($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                          $urandom_range(20000) - 4000, $urandom_range(4000) - 2000,
                          $urandom_range(4000) - 2000, $urandom_range(4000) - 2000);
        end
        else if (kind < 65)
            d = pack_axes($urandom_range(6) - 3, $urandom_range(6) - 3, $urandom_range(6) - 3,
                          $urandom_range(6) - 3, $urandom_range(6) - 3, $urandom_range(6) - 3);
        else
            d = {$urandom(), $urandom(), $urandom()};
        // occasionally zero whole axes to hit degenerate vectors
        if ($urandom_range(99) < 8)
            for (int i = 0; i < 6; i++)
                if ($urandom_range(1))
                    d[i*16 +: 16] = '0;
        return d;
    endfunction

    initial
    begin
        logic [95:0] directed_q[$];
        logic [15:0] decl_set[$];
        board        = new();
        cycles       = 0;
        calm         = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_q = '{
            pack_axes(0, 0, 0, 0, 0, 0),
            pack_axes(0, 0, 16384, 1000, 0, 0),
            pack_axes(0, 0, 16384, 0, 0, 0),
            pack_axes(0, 0, -16384, 1000, 200, 0),
            pack_axes(0, 0, -100, -500, 0, 0),
            pack_axes(0, -1, -100, -500, -1, 0),
            pack_axes(32767, 0, 0, 100, 100, 100),
            pack_axes(-32768, 0, 0, 100, -100, 100),
            pack_axes(0, 32767, 0, 0, 1000, 0),
            pack_axes(0, -32768, 0, 0, -1000, 0),
            pack_axes(0, 0, 0, 1234, -567, 890),
            pack_axes(0, 0, 16384, -1000, 0, 0),
            pack_axes(0, 0, 16384, -1000, -1, 0),
            pack_axes(0, 0, 16384, 0, 1000, 0),
            pack_axes(-32768, -32768, -32768, -32768, -32768, -32768),
            pack_axes(32767, 32767, 32767, 32767, 32767, 32767),
            pack_axes(32767, -32768, 32767, -32768, 32767, -32768),
            pack_axes(1, 1, 1, 1, 1, 1),
            pack_axes(-1, -1, -1, -1, -1, -1)
        };
        foreach (directed_q[i])
            send_sample(directed_q[i]);

        // sender pauses until everything has come back
        drain();

        decl_set = '{16'(-18000), 16'(18000), 16'h7fff, 16'h8000, 16'd0, 16'($urandom())};
        foreach (decl_set[p])
        begin
            write_declination(decl_set[p]);
            calm = (p == 2);
            if (p == 1)
                hold_request = 1'b1;
            repeat (12)
                send_sample(pack_axes(0, 0, 16384, $urandom_range(2000) - 1000,
                                      $urandom_range(2000) - 1000, 0));
            repeat (98)
                send_sample(random_sample());
        end
        calm = 1'b0;

        drain();
        repeat (PIPE_LAT + 20) @(posedge clk);
        if (board.errors == 0 && board.expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
